### rtl/tfp_pkg.sv
`default_nettype none

package tfp_pkg;

    // field and datapath widths
    localparam int R_W    = 32;
    localparam int Z_W    = 7;
    localparam int S_W    = 21;
    localparam int X_W    = 35;
    localparam int SQ_W   = 30;
    localparam int RAD_W  = 60;
    localparam int X2_W   = 46;
    localparam int X3_W   = 57;
    localparam int SX_W   = 41;
    localparam int SX2_W  = 52;
    localparam int PK_W   = 46;
    localparam int D_W    = 52;
    localparam int T_W    = 31;
    localparam int TNUM_W = 55;
    localparam int MNUM_W = 56;
    localparam int MQ_W   = 55;
    localparam int POT_W  = 57;

    // coefficient widths and the widths of the terms they produce
    localparam int KA_CW = 19;
    localparam int KB_CW = 22;
    localparam int KC_CW = 17;
    localparam int KD_CW = 25;
    localparam int KE_CW = 22;
    localparam int KF_CW = 17;
    localparam int TA_W  = SQ_W + KA_CW - 24;
    localparam int TB_W  = SX_W + KB_CW - 24;
    localparam int TC_W  = SX2_W + KC_CW - 24;
    localparam int TD_W  = X_W + KD_CW - 24;
    localparam int TE_W  = X2_W + KE_CW - 24;
    localparam int TF_W  = X3_W + KF_CW - 24;

    localparam logic [KA_CW-1:0] K_A = 19'd460870;
    localparam logic [KB_CW-1:0] K_B = 22'd2493094;
    localparam logic [KC_CW-1:0] K_C = 17'd122440;
    localparam logic [KD_CW-1:0] K_D = 25'd20854079;
    localparam logic [KE_CW-1:0] K_E = 22'd3862115;
    localparam logic [KF_CW-1:0] K_F = 17'd116501;

    localparam logic [D_W-1:0] ONE_D = 52'h1000000;
    localparam logic [T_W-1:0] ONE_T = 31'h1000000;

    localparam int MAX_ATOMIC_NUMBER_DEF = 118;
    localparam int Z_ENTRIES = 128;

    localparam logic [63:0] TF_NUM = 64'd100000000;
    localparam logic [63:0] TF_DEN = 64'd69395656;

    typedef struct packed {
        logic [R_W-1:0] radius;
        logic           last_point;
    } tfp_in_t;

    typedef struct packed {
        logic signed [POT_W-1:0] potential;
        logic                    floor_applied;
        logic                    last_out;
    } tfp_out_t;

    // cube root of z * 2^54 / 0.69395656 in Q3.18, evaluated at elaboration
    function automatic logic [S_W-1:0] scale_for(input int z);
        logic [127:0] num;
        logic [127:0] rem;
        logic [127:0] q;
        logic [127:0] c;
        logic [127:0] cand;
        begin
            num = 128'(64'(z) * TF_NUM) << 54;
            rem = '0;
            q   = '0;
            for (int i = 87; i >= 0; i--)
            begin
                rem = (rem << 1) | 128'(num[i]);
                if (rem >= 128'(TF_DEN))
                begin
                    rem  = rem - 128'(TF_DEN);
                    q[i] = 1'b1;
                end
            end
            c = '0;
            for (int i = 20; i >= 0; i--)
            begin
                cand = c | (128'd1 << i);
                if (cand * cand * cand <= q)
                    c = cand;
            end
            return c[S_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

### rtl/thomas_fermi_potential_eval_top.sv
`default_nettype none

// Thomas-Fermi potential evaluator. One radial point can be started in every clock
// cycle and busy never rises; each point gives one result on done/result in start
// order, and the receiver cannot stall. The pipeline runs through the 30-stage square
// root, the 31-stage charge divider and the 55-stage divide by radius, with six
// multiplier stages between them. The user must write atomic_number through cfg_we/cfg_wdata
// only while no point is in flight; the block itself does not enforce this.
module thomas_fermi_potential_eval_top
    import tfp_pkg::*;
#(
    parameter int MAX_ATOMIC_NUMBER = MAX_ATOMIC_NUMBER_DEF
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic [Z_W-1:0] cfg_wdata,
    input  wire logic           start,
    output logic                busy,
    input  wire tfp_in_t        item,
    output logic                done,
    output tfp_out_t            result
);

    typedef struct packed {
        logic [X_W-1:0] x;
        logic [R_W-1:0] radius;
        logic [Z_W-1:0] z;
        logic           last;
    } side_a_t;

    typedef struct packed {
        logic [SQ_W-1:0] sq;
        logic [X_W-1:0]  x;
        logic [R_W-1:0]  radius;
        logic [Z_W-1:0]  z;
        logic            last;
    } side_b_t;

    typedef struct packed {
        logic [TA_W-1:0] ka;
        logic [TD_W-1:0] kd;
        logic [R_W-1:0]  radius;
        logic [Z_W-1:0]  z;
        logic            last;
    } side_c_t;

    typedef struct packed {
        logic [PK_W-1:0] pk;
        logic [TB_W-1:0] kb;
        logic [R_W-1:0]  radius;
        logic [Z_W-1:0]  z;
        logic            last;
    } side_d_t;

    typedef struct packed {
        logic [R_W-1:0] radius;
        logic           last;
    } side_t_t;

    typedef struct packed {
        logic zero_r;
        logic floored;
        logic last;
    } side_m_t;

    localparam logic [S_W-1:0] SCALE_Z1 = scale_for(1);

    // cube-root scale table
    logic [S_W-1:0] scale_rom [0:Z_ENTRIES-1];
    for (genvar i = 0; i < Z_ENTRIES; i++)
    begin : g_rom
        localparam logic [S_W-1:0] SV = scale_for(i);
        assign scale_rom[i] = SV;
    end

    logic [Z_W-1:0] z_reg;
    logic [S_W-1:0] scale_reg;
    logic [Z_W-1:0] zc_next;

    assign zc_next = ({1'b0, cfg_wdata} > 8'(MAX_ATOMIC_NUMBER)) ?
                     Z_W'(MAX_ATOMIC_NUMBER) : cfg_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_reg     <= 7'd1;
            scale_reg <= SCALE_Z1;
        end
        else if (cfg_we)
        begin
            z_reg     <= zc_next;
            scale_reg <= scale_rom[zc_next];
        end
    end

    assign busy = 1'b0;

    // scaled radius
    logic            accept;
    logic [R_W+S_W-1:0] xprod;
    logic            x_v_reg;
    side_a_t         x_side_reg;

    assign accept = start && !busy;
    assign xprod  = item.radius * scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            x_v_reg <= 1'b0;
        else
            x_v_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        x_side_reg.x      <= xprod[R_W+S_W-1:18];
        x_side_reg.radius <= item.radius;
        x_side_reg.z      <= z_reg;
        x_side_reg.last   <= item.last_point;
    end

    // square root of x in Q.24
    logic            sq_v;
    logic [SQ_W-1:0] sq;
    side_a_t         sa;

    tfp_sqrt #(.RW(RAD_W), .SW($bits(side_a_t))) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (x_v_reg),
        .rad       ({1'b0, x_side_reg.x, 24'b0}),
        .side_in   (x_side_reg),
        .out_valid (sq_v),
        .root      (sq),
        .side_out  (sa)
    );

    // first product group: x^2, sqrt(x)*x, and the sqrt(x) and linear terms
    logic [X2_W-1:0] x2;
    logic [SX_W-1:0] sx;
    logic [TD_W-1:0] kd;
    logic [TA_W-1:0] ka;
    side_b_t         m1_reg [0:1];
    logic [1:0]      m1_v_reg;

    tfp_mulq #(.AW(X_W),  .BW(X_W))   u_x2 (.clk(clk), .a(sa.x), .b(sa.x), .p(x2));
    tfp_mulq #(.AW(X_W),  .BW(SQ_W))  u_sx (.clk(clk), .a(sa.x), .b(sq),   .p(sx));
    tfp_mulq #(.AW(X_W),  .BW(KD_CW)) u_kd (.clk(clk), .a(sa.x), .b(K_D),  .p(kd));
    tfp_mulq #(.AW(SQ_W), .BW(KA_CW)) u_ka (.clk(clk), .a(sq),   .b(K_A),  .p(ka));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m1_v_reg <= '0;
        else
            m1_v_reg <= {m1_v_reg[0], sq_v};
    end

    always_ff @(posedge clk)
    begin
        m1_reg[0].sq     <= sq;
        m1_reg[0].x      <= sa.x;
        m1_reg[0].radius <= sa.radius;
        m1_reg[0].z      <= sa.z;
        m1_reg[0].last   <= sa.last;
        m1_reg[1]        <= m1_reg[0];
    end

    // second product group
    logic [X3_W-1:0]  x3;
    logic [SX2_W-1:0] sx2;
    logic [TE_W-1:0]  ke;
    logic [TB_W-1:0]  kb;
    side_c_t          m2_reg [0:1];
    logic [1:0]       m2_v_reg;

    tfp_mulq #(.AW(X2_W), .BW(X_W))   u_x3  (.clk(clk), .a(x2), .b(m1_reg[1].x),  .p(x3));
    tfp_mulq #(.AW(X2_W), .BW(SQ_W))  u_sx2 (.clk(clk), .a(x2), .b(m1_reg[1].sq), .p(sx2));
    tfp_mulq #(.AW(X2_W), .BW(KE_CW)) u_ke  (.clk(clk), .a(x2), .b(K_E),          .p(ke));
    tfp_mulq #(.AW(SX_W), .BW(KB_CW)) u_kb  (.clk(clk), .a(sx), .b(K_B),          .p(kb));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m2_v_reg <= '0;
        else
            m2_v_reg <= {m2_v_reg[0], m1_v_reg[1]};
    end

    always_ff @(posedge clk)
    begin
        m2_reg[0].ka     <= ka;
        m2_reg[0].kd     <= kd;
        m2_reg[0].radius <= m1_reg[1].radius;
        m2_reg[0].z      <= m1_reg[1].z;
        m2_reg[0].last   <= m1_reg[1].last;
        m2_reg[1]        <= m2_reg[0];
    end

    // third product group, lower terms summed alongside
    logic [TF_W-1:0] kf;
    logic [TC_W-1:0] kc;
    side_d_t         m3_reg [0:1];
    logic [1:0]      m3_v_reg;

    tfp_mulq #(.AW(X3_W),  .BW(KF_CW)) u_kf (.clk(clk), .a(x3),  .b(K_F), .p(kf));
    tfp_mulq #(.AW(SX2_W), .BW(KC_CW)) u_kc (.clk(clk), .a(sx2), .b(K_C), .p(kc));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m3_v_reg <= '0;
        else
            m3_v_reg <= {m3_v_reg[0], m2_v_reg[1]};
    end

    always_ff @(posedge clk)
    begin
        m3_reg[0].pk     <= PK_W'(m2_reg[1].ka) + PK_W'(m2_reg[1].kd) + PK_W'(ke);
        m3_reg[0].kb     <= kb;
        m3_reg[0].radius <= m2_reg[1].radius;
        m3_reg[0].z      <= m2_reg[1].z;
        m3_reg[0].last   <= m2_reg[1].last;
        m3_reg[1]        <= m3_reg[0];
    end

    // denominator sums
    logic [D_W-1:0]  pos_reg;
    logic [TB_W-1:0] neg_reg;
    logic [R_W-1:0]  p_radius_reg;
    logic [Z_W-1:0]  p_z_reg;
    logic            p_last_reg;
    logic            p_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_v_reg <= 1'b0;
        else
            p_v_reg <= m3_v_reg[1];
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= ONE_D + D_W'(m3_reg[1].pk) + D_W'(kf) + D_W'(kc);
        neg_reg      <= m3_reg[1].kb;
        p_radius_reg <= m3_reg[1].radius;
        p_z_reg      <= m3_reg[1].z;
        p_last_reg   <= m3_reg[1].last;
    end

    // clamp the denominator to one, which also covers a non-positive difference
    logic [D_W-1:0] ddiff;
    logic           dgt;
    logic [D_W-1:0] den;
    side_t_t        td_side_in;

    assign ddiff = pos_reg - D_W'(neg_reg);
    assign dgt   = pos_reg > D_W'(neg_reg);
    assign den   = (dgt && (ddiff >= ONE_D)) ? ddiff : ONE_D;

    assign td_side_in.radius = p_radius_reg;
    assign td_side_in.last   = p_last_reg;

    logic           t_v;
    logic [T_W-1:0] t;
    side_t_t        td_side;

    tfp_div #(.NW(TNUM_W), .DW(D_W), .QW(T_W), .SW($bits(side_t_t))) u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_v_reg),
        .num       ({p_z_reg, 48'b0}),
        .den       (den),
        .side_in   (td_side_in),
        .out_valid (t_v),
        .quo       (t),
        .side_out  (td_side)
    );

    // floor of one on the effective charge, then divide by radius
    logic           floored;
    logic [T_W-1:0] tf;
    side_m_t        md_side_in;

    assign floored = t < ONE_T;
    assign tf      = floored ? ONE_T : t;

    assign md_side_in.zero_r  = td_side.radius == '0;
    assign md_side_in.floored = floored;
    assign md_side_in.last    = td_side.last;

    logic            m_v;
    logic [MQ_W-1:0] mq;
    side_m_t         md_side;

    tfp_div #(.NW(MNUM_W), .DW(R_W), .QW(MQ_W), .SW($bits(side_m_t))) u_mdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t_v),
        .num       ({1'b0, tf, 24'b0}),
        .den       (td_side.radius),
        .side_in   (md_side_in),
        .out_valid (m_v),
        .quo       (mq),
        .side_out  (md_side)
    );

    // zero radius gives the most negative potential
    logic [POT_W-1:0] mag;
    logic             done_reg;
    tfp_out_t         result_reg;

    assign mag = md_side.zero_r ? {1'b1, {(POT_W-1){1'b0}}} : POT_W'(mq);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= m_v;
    end

    always_ff @(posedge clk)
    begin
        result_reg.potential     <= POT_W'(0) - mag;
        result_reg.floor_applied <= md_side.floored;
        result_reg.last_out      <= md_side.last;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### rtl/tfp_mulq.sv
`default_nettype none

module tfp_mulq
#(
    parameter int AW = 35,
    parameter int BW = 35
)
(
    input  wire logic                 clk,
    input  wire logic [AW-1:0]        a,
    input  wire logic [BW-1:0]        b,
    output logic      [AW+BW-25:0]    p
);

    localparam int AL = AW / 2;
    localparam int AH = AW - AL;

    logic [AL+BW-1:0] lo_reg;
    logic [AH+BW-1:0] hi_reg;
    logic [AW+BW-1:0] full_next;
    logic [AW+BW-25:0] p_reg;

    // split the wide operand so each partial product stays narrow
    always_ff @(posedge clk)
    begin
        lo_reg <= a[AL-1:0] * b;
        hi_reg <= a[AW-1:AL] * b;
    end

    assign full_next = {hi_reg, {AL{1'b0}}} + (AW+BW)'(lo_reg);

    always_ff @(posedge clk)
    begin
        p_reg <= full_next[AW+BW-1:24];
    end

    assign p = p_reg;

endmodule

`default_nettype wire

### rtl/tfp_sqrt.sv
`default_nettype none

module tfp_sqrt
#(
    parameter int RW = 60,
    parameter int SW = 1
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [RW-1:0]       rad,
    input  wire logic [SW-1:0]       side_in,
    output logic                     out_valid,
    output logic      [RW/2-1:0]     root,
    output logic      [SW-1:0]       side_out
);

    localparam int RT = RW / 2;

    logic [RT:0]   v_reg;
    logic [RT:0]   rem_reg  [0:RT-1];
    logic [RW-1:0] rad_reg  [0:RT-1];
    logic [RT-1:0] root_reg [0:RT];
    logic [SW-1:0] side_reg [0:RT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[RT-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        rad_reg[0]  <= rad;
        root_reg[0] <= '0;
        side_reg[0] <= side_in;
    end

    // one root bit per stage, two radicand bits shifted in each time
    for (genvar k = 0; k < RT; k++)
    begin : g_stage
        logic [RT+2:0] rem2;
        logic [RT+2:0] trial;
        logic [RT+2:0] diff;
        logic          ge;
        logic [RT:0]   rem_next;
        logic [RT-1:0] root_next;

        always_comb
        begin
            rem2      = {rem_reg[k], rad_reg[k][RW-1:RW-2]};
            trial     = {1'b0, root_reg[k], 2'b01};
            diff      = rem2 - trial;
            ge        = rem2 >= trial;
            rem_next  = ge ? diff[RT:0] : rem2[RT:0];
            root_next = {root_reg[k][RT-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            root_reg[k+1] <= root_next;
            side_reg[k+1] <= side_reg[k];
        end

        if (k < RT - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[k+1] <= rem_next;
                rad_reg[k+1] <= {rad_reg[k][RW-3:0], 2'b00};
            end
        end
    end

    assign out_valid = v_reg[RT];
    assign root      = root_reg[RT];
    assign side_out  = side_reg[RT];

endmodule

`default_nettype wire

### rtl/tfp_div.sv
`default_nettype none

module tfp_div
#(
    parameter int NW = 55,
    parameter int DW = 52,
    parameter int QW = 31,
    parameter int SW = 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [NW-1:0]     num,
    input  wire logic [DW-1:0]     den,
    input  wire logic [SW-1:0]     side_in,
    output logic                   out_valid,
    output logic      [QW-1:0]     quo,
    output logic      [SW-1:0]     side_out
);

    logic [QW:0]   v_reg;
    logic [DW-1:0] rem_reg  [0:QW-1];
    logic [QW-1:0] low_reg  [0:QW-1];
    logic [DW-1:0] den_reg  [0:QW-1];
    logic [QW-1:0] q_reg    [0:QW];
    logic [SW-1:0] side_reg [0:QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[QW-1:0], in_valid};
    end

    // upper numerator bits sit below the divisor as the quotient fits in QW bits
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= DW'(num[NW-1:QW]);
        low_reg[0]  <= num[QW-1:0];
        den_reg[0]  <= den;
        q_reg[0]    <= '0;
        side_reg[0] <= side_in;
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[k], low_reg[k][QW-1]};
            diff     = trial - {1'b0, den_reg[k]};
            ge       = trial >= {1'b0, den_reg[k]};
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        end

        always_ff @(posedge clk)
        begin
            q_reg[k+1]    <= {q_reg[k][QW-2:0], ge};
            side_reg[k+1] <= side_reg[k];
        end

        if (k < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[k+1] <= rem_next;
                low_reg[k+1] <= {low_reg[k][QW-2:0], 1'b0};
                den_reg[k+1] <= den_reg[k];
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign quo       = q_reg[QW];
    assign side_out  = side_reg[QW];

endmodule

`default_nettype wire
